// ===== rtl/core/bmcb_pkg.sv =====
`timescale 1ns / 1ps
package bmcb_pkg;

  localparam logic [1:0] MODE_FEED  = 2'd0;
  localparam logic [1:0] MODE_READ  = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;

  localparam int unsigned NUM_SLOTS = 16;
  localparam int unsigned CNT_W     = 32;
  localparam int unsigned VALUE_W   = 34;

  localparam logic [3:0] NIBBLE_MASK = 4'hF;

  typedef logic [3:0]         slot_t;
  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [VALUE_W-1:0] value_t;

  // Update request sent to the counter bank for one executed transaction.
  typedef struct packed {
    logic       feed;
    logic       clear;
    slot_t      pri_slot;
    logic [8:0] pri_amt;
    slot_t      sec_slot;
    logic [4:0] sec_amt;
  } bank_cmd_t;

endpackage

// ===== rtl/core/bmcb_bank.sv =====
`timescale 1ns / 1ps
module bmcb_bank (
  input  logic              clk,
  input  logic              rst,
  input  bmcb_pkg::bank_cmd_t cmd,
  input  logic [1:0]        rd_channel,
  output bmcb_pkg::value_t  rd_value
);
  import bmcb_pkg::*;

  // Slot layout is half*8 + channel*2 + direction; the 4-bit slot addresses
  // 16 counters, all of which are kept.
  cnt_t cnt [NUM_SLOTS];

  always_ff @(posedge clk) begin
    for (int k = 0; k < NUM_SLOTS; k++) begin
      if (rst || cmd.clear) begin
        cnt[k] <= '0;
      end else if (cmd.feed) begin
        if (cmd.pri_slot == 4'(k)) begin
          cnt[k] <= cnt[k] + CNT_W'(cmd.pri_amt);
        end else if (cmd.sec_slot == 4'(k)) begin
          cnt[k] <= cnt[k] + CNT_W'(cmd.sec_amt);
        end
      end
    end
  end

  value_t up_pos;
  value_t up_neg;
  value_t dn_pos;
  value_t dn_neg;

  assign up_pos = VALUE_W'(cnt[{1'b0, rd_channel, 1'b1}]);
  assign up_neg = VALUE_W'(cnt[{1'b0, rd_channel, 1'b0}]);
  assign dn_pos = VALUE_W'(cnt[{1'b1, rd_channel, 1'b1}]);
  assign dn_neg = VALUE_W'(cnt[{1'b1, rd_channel, 1'b0}]);

  assign rd_value = (up_pos - up_neg) - (dn_pos - dn_neg);

endmodule

// ===== rtl/core/byte_mixing_counter_bank_top.sv =====
`timescale 1ns / 1ps
// Byte mixing counter bank. Each input transaction is a feed, a read or a
// clear, chosen by the mode in tuser. A feed adds byte+1 to one 32-bit
// counter and nibble+1 to a counter on the opposite half, chosen from the
// byte and a 5-bit stream position that first_of_call restarts at zero. A
// read produces one output transaction with the signed 34-bit channel value
// (inc plus - inc minus) - (dec plus - dec minus); feeds, clears and mode 3
// produce none. A clear zeroes all counters and the position. One
// transaction is taken per clock unless the input is held up as below: it
// sits in the input register, then updates the counters or loads the
// output register, where a read result is offered and held until taken.
// Only a read waiting on a full, stalled output register holds up the
// input.
module byte_mixing_counter_bank_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic [4:0]  s_tuser,   // [1:0] mode, [2] first_of_call, [4:3] channel
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [33:0] channel_value, [39:34] zero
  output logic [1:0]  m_tuser    // [1:0] channel_echo
);
  import bmcb_pkg::*;

  // Input register.
  logic       in_valid;
  logic [1:0] in_mode;
  logic [7:0] in_byte;
  logic       in_first;
  logic [1:0] in_channel;

  // Output register.
  logic       out_valid;
  value_t     out_value;
  logic [1:0] out_channel;

  logic [4:0] position;

  logic       exec_go;
  logic       is_read;
  logic [4:0] pos_i;
  logic [1:0] salt;
  logic [1:0] ch;
  logic [1:0] och;
  logic       half;
  logic       dir;
  bank_cmd_t  cmd;
  value_t     rd_value;

  assign is_read  = (in_mode == MODE_READ);
  assign exec_go  = in_valid && (!is_read || !out_valid || m_tready);
  assign s_tready = !in_valid || exec_go;

  assign pos_i = in_first ? 5'd0 : position;
  assign salt  = pos_i[1:0] ^ pos_i[4:3];
  assign ch    = in_byte[1:0] ^ salt;
  assign och   = ch + 2'd1;
  assign half  = pos_i[2] ^ in_byte[6];
  assign dir   = pos_i[1] ^ in_byte[3];

  always_comb begin
    cmd          = '0;
    cmd.feed     = exec_go && (in_mode == MODE_FEED);
    cmd.clear    = exec_go && (in_mode == MODE_CLEAR);
    cmd.pri_slot = {half, ch, dir};
    cmd.pri_amt  = {1'b0, in_byte} + 9'd1;
    cmd.sec_slot = {~half, och, ~dir};
    // The partner counter takes the high nibble in its minus direction when
    // the byte went plus, else the low nibble in its plus direction.
    if (dir) begin
      cmd.sec_amt = {1'b0, in_byte[7:4]} + 5'd1;
    end else begin
      cmd.sec_amt = {1'b0, in_byte[3:0] & NIBBLE_MASK} + 5'd1;
    end
  end

  bmcb_bank u_bank (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .rd_channel (in_channel),
    .rd_value   (rd_value)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_mode    <= s_tuser[1:0];
      in_first   <= s_tuser[2];
      in_channel <= s_tuser[4:3];
      in_byte    <= s_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      position <= '0;
    end else if (cmd.feed) begin
      position <= pos_i + 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (exec_go && is_read) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_go && is_read) begin
      out_value   <= rd_value;
      out_channel <= in_channel;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {6'd0, out_value};
  assign m_tuser  = out_channel;

endmodule
